FILE: rtl/ilb_pkg.sv
// shared types, codes and defaults for the indexed list buffer
package ilb_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int WORD_WIDTH_DEFAULT = 32;
	localparam int CMD_W              = 3;
	localparam int STATUS_W           = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_ERASE  = 3'd3,
		CMD_READ   = 3'd4,
		CMD_WRITE  = 3'd5,
		CMD_RESIZE = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		OUT_FREE = 1'b0,
		OUT_HELD = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} dp_ctrl_t;

	typedef struct packed {
		status_t status;
	} dp_stat_t;

endpackage

FILE: rtl/ilb_ctrl.sv
// controller: output register occupancy, handshakes and commit decision
module ilb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  ilb_pkg::dp_stat_t   dp_stat,
	output ilb_pkg::dp_ctrl_t   dp_ctrl
);

	ilb_pkg::state_t state_q;
	ilb_pkg::state_t state_next;
	logic            load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilb_pkg::OUT_FREE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ilb_pkg::OUT_FREE: begin
				if (load) state_next = ilb_pkg::OUT_HELD;
			end
			ilb_pkg::OUT_HELD: begin
				if (!load && m_tready) state_next = ilb_pkg::OUT_FREE;
			end
			default: begin
				state_next = ilb_pkg::OUT_FREE;
			end
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		m_tvalid       = 1'b0;
		case (state_q)
			ilb_pkg::OUT_FREE: begin
				s_tready = 1'b1;
			end
			ilb_pkg::OUT_HELD: begin
				s_tready = m_tready;
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		load           = s_tvalid && s_tready;
		dp_ctrl.load   = load;
		dp_ctrl.commit = load && (dp_stat.status == ilb_pkg::STAT_OK);
	end

endmodule

FILE: rtl/ilb_datapath.sv
// datapath: row of element cells, length register, checks and result register
module ilb_datapath #(
	parameter int DEPTH      = ilb_pkg::DEPTH_DEFAULT,
	parameter int WORD_WIDTH = ilb_pkg::WORD_WIDTH_DEFAULT,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ilb_pkg::cmd_t         command,
	input  logic [CNT_W-1:0]      position,
	input  logic [WORD_WIDTH-1:0] word_in,
	input  ilb_pkg::dp_ctrl_t     dp_ctrl,
	output ilb_pkg::dp_stat_t     dp_stat,
	output logic [WORD_WIDTH-1:0] read_word,
	output logic [CNT_W-1:0]      count,
	output logic                  is_empty,
	output ilb_pkg::status_t      status
);

	localparam int               IDX_W   = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	logic [WORD_WIDTH-1:0] cells_q [DEPTH];
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      len_next;
	logic [CNT_W-1:0]      count_next;
	logic [WORD_WIDTH-1:0] rd_word;
	ilb_pkg::status_t      st;

	logic [WORD_WIDTH-1:0] read_word_q;
	logic [CNT_W-1:0]      count_q;
	ilb_pkg::status_t      status_q;

	always_comb begin
		st       = ilb_pkg::STAT_OK;
		len_next = len_q;
		case (command)
			ilb_pkg::CMD_APPEND: begin
				if (len_q >= DEPTH_C) st = ilb_pkg::STAT_FULL;
				len_next = len_q + ONE_C;
			end
			ilb_pkg::CMD_REMOVE: begin
				if (len_q == '0) st = ilb_pkg::STAT_EMPTY;
				len_next = len_q - ONE_C;
			end
			ilb_pkg::CMD_INSERT: begin
				if (len_q >= DEPTH_C) st = ilb_pkg::STAT_FULL;
				else if (position > len_q) st = ilb_pkg::STAT_RANGE;
				len_next = len_q + ONE_C;
			end
			ilb_pkg::CMD_ERASE: begin
				if (len_q == '0) st = ilb_pkg::STAT_EMPTY;
				else if (position >= len_q) st = ilb_pkg::STAT_RANGE;
				len_next = len_q - ONE_C;
			end
			ilb_pkg::CMD_READ, ilb_pkg::CMD_WRITE: begin
				if (position >= len_q) st = ilb_pkg::STAT_RANGE;
			end
			ilb_pkg::CMD_RESIZE: begin
				if (position > DEPTH_C) st = ilb_pkg::STAT_RANGE;
				len_next = position;
			end
			default: begin
				st = ilb_pkg::STAT_OK;
			end
		endcase
		dp_stat.status = st;
		if (command == ilb_pkg::CMD_READ && st == ilb_pkg::STAT_OK) begin
			rd_word = cells_q[position[IDX_W-1:0]];
		end else begin
			rd_word = '0;
		end
	end

	assign count_next = dp_ctrl.commit ? len_next : len_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX    = CNT_W'(i);
		localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(i + 1);
		logic [WORD_WIDTH-1:0] below;
		logic [WORD_WIDTH-1:0] above;
		logic [WORD_WIDTH-1:0] cell_next;

		if (i > 0) begin : g_below
			assign below = cells_q[i-1];
		end else begin : g_no_below
			assign below = cells_q[i];
		end
		if (i < DEPTH - 1) begin : g_above
			assign above = cells_q[i+1];
		end else begin : g_no_above
			assign above = cells_q[i];
		end

		always_comb begin
			cell_next = cells_q[i];
			case (command)
				ilb_pkg::CMD_APPEND: begin
					if (IDX == len_q) cell_next = word_in;
				end
				ilb_pkg::CMD_INSERT: begin
					if (IDX == position) cell_next = word_in;
					else if (IDX > position && IDX <= len_q) cell_next = below;
				end
				ilb_pkg::CMD_ERASE: begin
					if (IDX >= position && IDX_P1 < len_q) cell_next = above;
				end
				ilb_pkg::CMD_WRITE: begin
					if (IDX == position) cell_next = word_in;
				end
				ilb_pkg::CMD_RESIZE: begin
					if (IDX >= len_q && IDX < position) cell_next = word_in;
				end
				default: begin
					cell_next = cells_q[i];
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (dp_ctrl.commit) cells_q[i] <= cell_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (dp_ctrl.commit) begin
			len_q <= len_next;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.load) begin
			read_word_q <= rd_word;
			count_q     <= count_next;
			status_q    <= st;
		end
	end

	assign read_word = read_word_q;
	assign count     = count_q;
	assign is_empty  = (count_q == '0);
	assign status    = status_q;

endmodule

FILE: rtl/indexed_list_buffer_top.sv
// top level of the indexed list buffer
//
// an ordered list of up to DEPTH words held in a row of cells. each transfer
// on the slave side carries one command (append, remove last, insert, erase,
// read, write, resize); each produces exactly one result transfer on the
// master side with the read word, the new count, an empty flag and a status.
// full, empty and bad-index commands report a status and change nothing.
// results are registered: an accepted command shows its result from the cycle
// after acceptance on. throughput: one command per cycle while the receiver takes
// each result; every cell takes its shifted, written or filled value in the cycle
// of acceptance, so only the single result register sets the pace.
// when the receiver stalls, the result register holds and s_tready drops
// until the result is taken; a new command is accepted in the same cycle the
// held result leaves.
// reset clears the length and empties the result register; element cells
// have no reset and are only read after being written.
module indexed_list_buffer_top #(
	parameter int DEPTH      = ilb_pkg::DEPTH_DEFAULT,
	parameter int WORD_WIDTH = ilb_pkg::WORD_WIDTH_DEFAULT,
	parameter int CNT_W      = $clog2(DEPTH + 1),
	parameter int IN_W       = ((ilb_pkg::CMD_W + CNT_W + WORD_WIDTH + 7) / 8) * 8,
	parameter int OUT_W      = ((WORD_WIDTH + CNT_W + 1 + ilb_pkg::STATUS_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // command, position, word_in
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // read_word, count, is_empty, status
);

	localparam int POS_LO  = ilb_pkg::CMD_W;
	localparam int WORD_LO = POS_LO + CNT_W;
	localparam int IN_USED = WORD_LO + WORD_WIDTH;

	ilb_pkg::dp_ctrl_t     dp_ctrl;
	ilb_pkg::dp_stat_t     dp_stat;
	ilb_pkg::cmd_t         command;
	logic [CNT_W-1:0]      position;
	logic [WORD_WIDTH-1:0] word_in;
	logic [WORD_WIDTH-1:0] read_word;
	logic [CNT_W-1:0]      count;
	logic                  is_empty;
	ilb_pkg::status_t      status;

	assign command   = ilb_pkg::cmd_t'(s_tdata[ilb_pkg::CMD_W-1:0]);
	assign position  = s_tdata[WORD_LO-1:POS_LO];
	assign word_in   = s_tdata[IN_USED-1:WORD_LO];

	ilb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_stat  (dp_stat),
		.dp_ctrl  (dp_ctrl)
	);

	ilb_datapath #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH),
		.CNT_W      (CNT_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (command),
		.position  (position),
		.word_in   (word_in),
		.dp_ctrl   (dp_ctrl),
		.dp_stat   (dp_stat),
		.read_word (read_word),
		.count     (count),
		.is_empty  (is_empty),
		.status    (status)
	);

	assign m_tdata = OUT_W'({status, is_empty, count, read_word});

endmodule

FILE: rtl/ilb_checker.sv
// port-level checks for the indexed list buffer, bound to the top level
module ilb_checker #(
	parameter int DEPTH      = ilb_pkg::DEPTH_DEFAULT,
	parameter int WORD_WIDTH = ilb_pkg::WORD_WIDTH_DEFAULT,
	parameter int CNT_W      = $clog2(DEPTH + 1),
	parameter int OUT_W      = ((WORD_WIDTH + CNT_W + 1 + ilb_pkg::STATUS_W + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int CNT_LO  = WORD_WIDTH;
	localparam int STAT_LO = WORD_WIDTH + CNT_W + 1;

	logic [WORD_WIDTH-1:0] read_word;
	logic [CNT_W-1:0]      count;
	ilb_pkg::status_t      status;

	assign read_word = m_tdata[WORD_WIDTH-1:0];
	assign count     = m_tdata[CNT_LO+CNT_W-1:CNT_LO];
	assign status    = ilb_pkg::status_t'(m_tdata[STAT_LO+ilb_pkg::STATUS_W-1:STAT_LO]);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("command taken while result stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted command");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == ilb_pkg::STAT_FULL |-> count == CNT_W'(DEPTH))
		else $error("full status without full count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status != ilb_pkg::STAT_OK |-> read_word == '0)
		else $error("failed command returned data");

endmodule

bind indexed_list_buffer_top ilb_checker #(
	.DEPTH      (DEPTH),
	.WORD_WIDTH (WORD_WIDTH),
	.CNT_W      (CNT_W),
	.OUT_W      (OUT_W)
) u_ilb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/ilb_result_checker.sv
// result checker for the indexed list buffer: predicts each result and compares it
`timescale 1ns / 1ps
module ilb_result_checker import ilb_pkg::*; #(
	parameter int LIST_CAP = 16,
	parameter int IN_W     = 40,
	parameter int OUT_W    = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // command, position, word_in
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // read_word, count, is_empty, status
	output int               mismatches,
	output int               outstanding
);

	// same bit order as m_tdata, last member in the lowest bits
	typedef struct packed {
		status_t     status;
		logic        empty;
		logic [4:0]  count;
		logic [31:0] word;
	} list_result_t;

	logic [31:0]  cells [LIST_CAP];
	int unsigned  list_len;
	list_result_t pending_results[$];
	list_result_t got;
	list_result_t want;

	function automatic list_result_t run_list_command(input logic [2:0] op,
			input int unsigned pos, input logic [31:0] w);
		list_result_t r;
		int unsigned  i;
		r.word   = '0;
		r.status = STAT_OK;
		case (op)
			CMD_APPEND: begin
				if (list_len >= LIST_CAP) r.status = STAT_FULL;
				else begin
					cells[list_len] = w;
					list_len++;
				end
			end
			CMD_REMOVE: begin
				if (list_len == 0) r.status = STAT_EMPTY;
				else list_len--;
			end
			CMD_INSERT: begin
				if (list_len >= LIST_CAP) r.status = STAT_FULL;
				else if (pos > list_len) r.status = STAT_RANGE;
				else begin
					for (i = list_len; i > pos; i--) cells[i] = cells[i-1];
					cells[pos] = w;
					list_len++;
				end
			end
			CMD_ERASE: begin
				if (list_len == 0) r.status = STAT_EMPTY;
				else if (pos >= list_len) r.status = STAT_RANGE;
				else begin
					for (i = pos; i + 1 < list_len; i++) cells[i] = cells[i+1];
					list_len--;
				end
			end
			CMD_READ: begin
				if (pos >= list_len) r.status = STAT_RANGE;
				else r.word = cells[pos];
			end
			CMD_WRITE: begin
				if (pos >= list_len) r.status = STAT_RANGE;
				else cells[pos] = w;
			end
			CMD_RESIZE: begin
				if (pos > LIST_CAP) r.status = STAT_RANGE;
				else begin
					for (i = list_len; i < pos; i++) cells[i] = w;
					list_len = pos;
				end
			end
			default: begin
			end
		endcase
		r.count = 5'(list_len);
		r.empty = (list_len == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len    = 0;
			pending_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[39:0];
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with nothing expected: ",
							"word %h count %0d empty %b status %0d",
							got.word, got.count, got.empty, got.status);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected word %h count %0d empty %b status %0d, ",
								want.word, want.count, want.empty, want.status,
								"got word %h count %0d empty %b status %0d",
								got.word, got.count, got.empty, got.status);
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_results = {pending_results,
					run_list_command(s_tdata[2:0], 32'(s_tdata[7:3]), s_tdata[39:8])};
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: bench/tb_indexed_list_buffer_top.sv
// testbench top for the indexed list buffer: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_indexed_list_buffer_top;
	import ilb_pkg::*;

	localparam int               LIST_CAP   = 16;
	localparam int               IN_W       = 40;
	localparam int               OUT_W      = 40;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	int               mismatches;
	int               outstanding;
	logic             steady;
	int unsigned      guess_len;
	int               n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	indexed_list_buffer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ilb_result_checker #(.LIST_CAP(LIST_CAP), .IN_W(IN_W), .OUT_W(OUT_W)) u_result_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// one command transfer, with random idle cycles ahead of it unless steady is set
	task automatic issue_command(input logic [2:0] op, input int unsigned pos,
			input logic [31:0] w);
		while (!steady && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {w, 5'(pos), op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		// rough length tracking, only to steer positions
		case (op)
			CMD_APPEND: if (guess_len < LIST_CAP) guess_len++;
			CMD_REMOVE: if (guess_len > 0) guess_len--;
			CMD_INSERT: if (guess_len < LIST_CAP && pos <= guess_len) guess_len++;
			CMD_ERASE:  if (guess_len > 0 && pos < guess_len) guess_len--;
			CMD_RESIZE: if (pos <= LIST_CAP) guess_len = pos;
			default: begin
			end
		endcase
	endtask

	task automatic random_command(input int idx);
		logic [2:0]  op;
		int unsigned pos;
		logic [31:0] w;
		int unsigned pick;
		int unsigned wsel;
		pick = $urandom_range(99);
		// alternate growing and shrinking stretches so the list reaches full and empty
		if ((idx / 60) % 2 == 0) begin
			if (pick < 30) op = CMD_APPEND;
			else if (pick < 55) op = CMD_INSERT;
			else if (pick < 60) op = CMD_REMOVE;
			else if (pick < 65) op = CMD_ERASE;
			else if (pick < 80) op = CMD_READ;
			else if (pick < 92) op = CMD_WRITE;
			else op = CMD_RESIZE;
		end else begin
			if (pick < 8) op = CMD_APPEND;
			else if (pick < 16) op = CMD_INSERT;
			else if (pick < 36) op = CMD_REMOVE;
			else if (pick < 58) op = CMD_ERASE;
			else if (pick < 76) op = CMD_READ;
			else if (pick < 90) op = CMD_WRITE;
			else op = CMD_RESIZE;
		end
		pos = $urandom_range(LIST_CAP);
		if ($urandom_range(99) < 80) begin
			if (op == CMD_INSERT) pos = $urandom_range(guess_len);
			else if ((op == CMD_READ || op == CMD_WRITE || op == CMD_ERASE) && guess_len > 0)
				pos = $urandom_range(guess_len - 1);
		end
		wsel = $urandom_range(9);
		if (wsel == 0) w = '0;
		else if (wsel == 1) w = '1;
		else w = $urandom;
		issue_command(op, pos, w);
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= steady || ($urandom_range(99) >= 31);
		end
	end

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		steady    = 1'b0;
		guess_len = 0;
		arst_n    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		issue_command(CMD_REMOVE, 0, 32'h0);
		issue_command(CMD_ERASE, 0, 32'h0);
		issue_command(CMD_READ, 0, 32'h0);
		issue_command(CMD_WRITE, 0, 32'h1);
		issue_command(CMD_INSERT, 1, 32'h2);
		issue_command(CMD_INSERT, 0, 32'hFFFF_FFFF);
		issue_command(CMD_APPEND, 0, 32'h0000_0000);
		issue_command(CMD_INSERT, 1, 32'h1234_5678);
		issue_command(CMD_RESIZE, 16, 32'hA5A5_A5A5);
		issue_command(CMD_APPEND, 0, 32'h5A5A_5A5A);
		issue_command(CMD_INSERT, 3, 32'h5A5A_5A5A);
		issue_command(CMD_RESIZE, 17, 32'h0);
		issue_command(CMD_RESIZE, 31, 32'h0);
		issue_command(CMD_READ, 15, 32'h0);
		issue_command(CMD_READ, 16, 32'h0);
		issue_command(CMD_WRITE, 15, 32'hFFFF_FFFF);
		issue_command(CMD_ERASE, 16, 32'h0);
		issue_command(CMD_ERASE, 0, 32'h0);
		issue_command(CMD_READ, 0, 32'h0);
		issue_command(CMD_RESIZE, 15, 32'hDEAD_0000);
		issue_command(CMD_INSERT, 15, 32'h0F0F_0F0F);
		issue_command(CMD_RESIZE, 2, 32'h0);
		issue_command(CMD_UNUSED, 31, 32'hFFFF_FFFF);
		issue_command(CMD_RESIZE, 0, 32'h0);
		issue_command(CMD_RESIZE, 0, 32'h0);

		for (n = 0; n < 450; n++) begin
			steady = (n >= 150 && n < 270);
			random_command(n);
		end
		steady   = 1'b0;
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
